[hw/rtl/osb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// osb_pkg: shared types and constants of the oriented scanline pen blitter
// Holds command codes, register indexes, size limits and the configuration
// record that the register file hands to the datapath.
// ----------------------------------------------------------------------------
package osb_pkg;

    // Input commands.
    localparam logic [1:0] CMD_SPAN  = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_PEN   = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_PENS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_PIXELS  = 3'd6;
    localparam int unsigned CFG_DATA_W = 17;

    // Size limits; register writes above them saturate.
    localparam logic [12:0] MAX_WIDTH  = 13'd4096;
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;
    localparam logic [13:0] MAX_STRIDE = 14'd8192;

    // Pen table geometry.
    localparam int unsigned PEN_COUNT = 4096;
    localparam int unsigned PEN_IDX_W = $clog2(PEN_COUNT);
    localparam int unsigned PIX_W     = 16;

    // Address widths: internal accumulator and the visible write address.
    localparam int unsigned ADDR_W     = 27;
    localparam int unsigned OUT_ADDR_W = 25;

    typedef struct packed {
        logic [2:0]         orientation;
        logic               use_pens;
        logic signed [16:0] skip_pen;
        logic [12:0]        frame_width;
        logic [12:0]        frame_height;
        logic [13:0]        line_stride;
        logic               wide_pixels;
    } t_cfg;

endpackage
`default_nettype wire

[hw/rtl/oriented_scanline_pen_blitter_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oriented_scanline_pen_blitter_top: oriented scanline blitter with pen table
// Turns a stream of span starts, pixels and pen loads into frame buffer
// writes, honoring flip and swap orientation, pen mapping and transparency.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Carries
//  -------   ---------  ------------------------  --------------------------------
//  in        sink       i_in_valid / o_in_ready   cmd, span x/y, pixel, last, pen
//  out       source     o_out_valid / i_out_ready write address, write data
//  cfg       sink       i_cfg_valid / o_cfg_ready register index, write data
//
//  One input beat is taken every cycle while the result path flows. A pixel
//  beat that is accepted passes the registered pen table read and then the
//  output register before it shows up on the out channel.
//  Span starts, pen loads, transparent pixels and unknown commands give no
//  out beat. When the out channel stalls, the pen read stage still takes one
//  more beat, then o_in_ready drops until the output register drains.
//  Reset (synchronous, active low) empties both stages, restores the register
//  defaults and sets the address to zero with a step of one; the pen table
//  is not cleared. The cfg channel is always ready.
//
module oriented_scanline_pen_blitter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [11:0] i_span_x,
    input  wire logic [11:0] i_span_y,
    input  wire logic [15:0] i_pixel,
    input  wire logic        i_last,
    input  wire logic [11:0] i_pen_index,
    input  wire logic [15:0] i_pen_value,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [24:0]      o_write_address,
    output logic [15:0]      o_write_data,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data
);
    import osb_pkg::*;

    t_cfg                  w_cfg;
    logic                  w_in_acc;
    logic                  w_is_span;
    logic                  w_is_pixel;
    logic                  w_is_pen;
    logic                  w_transparent;
    logic                  w_out_free;
    logic [ADDR_W-1:0]     w_cur_addr;
    logic [PIX_W-1:0]      w_pen_data;
    logic [PIX_W-1:0]      w_src;
    logic [PIX_W-1:0]      w_data;

    // Stage 1: pixel beat waiting for its pen table read.
    logic                  r_s1_valid;
    logic [OUT_ADDR_W-1:0] r_s1_address;
    logic [PIX_W-1:0]      r_s1_pixel;

    // Stage 2: output register.
    logic                  r_out_valid;
    logic [OUT_ADDR_W-1:0] r_out_address;
    logic [PIX_W-1:0]      r_out_data;

    // The configuration registers take a write in every cycle.
    assign o_cfg_ready = 1'b1;

    osb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // The output register is free when it is empty or is being taken now.
    assign w_out_free = !r_out_valid || i_out_ready;
    // Stage 1 moves on whenever the output register can take its content.
    assign o_in_ready = !r_s1_valid || w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_is_span  = w_in_acc && (i_cmd == CMD_SPAN);
    assign w_is_pixel = w_in_acc && (i_cmd == CMD_PIXEL);
    assign w_is_pen   = w_in_acc && (i_cmd == CMD_PEN);

    // Only a non-negative transparent pen can match; the span mark i_last
    // has no bearing on addressing, which keeps stepping past it.
    assign w_transparent = !w_cfg.skip_pen[16]
                        && (i_pixel == w_cfg.skip_pen[15:0]);

    osb_addr u_addr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_span_load  (w_is_span),
        .i_pixel_step (w_is_pixel),
        .i_span_x     (i_span_x),
        .i_span_y     (i_span_y),
        .i_cfg        (w_cfg),
        .o_address    (w_cur_addr)
    );

    osb_pen_ram u_pen_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_is_pen),
        .i_wr_addr (i_pen_index[PEN_IDX_W-1:0]),
        .i_wr_data (i_pen_value),
        .i_rd_en   (w_is_pixel),
        .i_rd_addr (i_pixel[PEN_IDX_W-1:0]),
        .o_rd_data (w_pen_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= w_is_pixel && !w_transparent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_is_pixel) begin
            r_s1_address <= w_cur_addr[OUT_ADDR_W-1:0];
            r_s1_pixel   <= i_pixel;
        end
    end

    // Pen mapping and destination depth are applied on the way out.
    assign w_src  = w_cfg.use_pens ? w_pen_data : r_s1_pixel;
    assign w_data = w_cfg.wide_pixels ? w_src : {8'd0, w_src[7:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_out_address <= r_s1_address;
            r_out_data    <= w_data;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_address = r_out_address;
    assign o_write_data    = r_out_data;

endmodule
`default_nettype wire

[hw/rtl/osb_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// osb_cfg: configuration register file
// Seven registers written by index; size registers saturate at their limits.
// ----------------------------------------------------------------------------
module osb_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr_en,
    input  wire logic [osb_pkg::CFG_IDX_W-1:0]   i_index,
    input  wire logic [osb_pkg::CFG_DATA_W-1:0]  i_data,
    output osb_pkg::t_cfg                        o_cfg
);
    import osb_pkg::*;

    t_cfg        r_cfg;
    t_cfg        n_cfg;
    logic [12:0] w_d13;
    logic [13:0] w_d14;

    assign w_d13 = i_data[12:0];
    assign w_d14 = i_data[13:0];

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_index)
                REG_ORIENTATION:  n_cfg.orientation     = i_data[2:0];
                REG_USE_PENS:     n_cfg.use_pens        = i_data[0];
                REG_TRANSPARENT:  n_cfg.skip_pen        = i_data[16:0];
                REG_FRAME_WIDTH:  n_cfg.frame_width  = (w_d13 > MAX_WIDTH)  ? MAX_WIDTH  : w_d13;
                REG_FRAME_HEIGHT: n_cfg.frame_height = (w_d13 > MAX_HEIGHT) ? MAX_HEIGHT : w_d13;
                REG_LINE_STRIDE:  n_cfg.line_stride  = (w_d14 > MAX_STRIDE) ? MAX_STRIDE : w_d14;
                REG_WIDE_PIXELS:  n_cfg.wide_pixels     = i_data[0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.orientation     <= 3'd0;
            r_cfg.use_pens        <= 1'b0;
            r_cfg.skip_pen        <= -17'sd1;
            r_cfg.frame_width     <= 13'd256;
            r_cfg.frame_height    <= 13'd256;
            r_cfg.line_stride     <= 14'd256;
            r_cfg.wide_pixels     <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[hw/rtl/osb_addr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// osb_addr: oriented write address generator
// On a span start, maps the logical start point through the orientation and
// loads the address accumulator and its step; each pixel advances it by the step.
// ----------------------------------------------------------------------------
module osb_addr (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_span_load,
    input  wire logic                         i_pixel_step,
    input  wire logic [11:0]                  i_span_x,
    input  wire logic [11:0]                  i_span_y,
    input  osb_pkg::t_cfg                     i_cfg,
    output logic [osb_pkg::ADDR_W-1:0]        o_address
);
    import osb_pkg::*;

    logic [ADDR_W-1:0] r_cur;
    logic [ADDR_W-1:0] n_cur;
    logic [ADDR_W-1:0] r_step;
    logic [ADDR_W-1:0] n_step;

    logic              w_swap;
    logic              w_neg;
    logic [ADDR_W-1:0] w_sx;
    logic [ADDR_W-1:0] w_sy;
    logic [ADDR_W-1:0] w_tx;
    logic [ADDR_W-1:0] w_ty;
    logic [ADDR_W-1:0] w_adv;
    logic [ADDR_W-1:0] w_prod;
    logic [ADDR_W-1:0] w_start;

    always_comb begin
        w_swap = i_cfg.orientation[2];
        w_sx   = ADDR_W'(w_swap ? i_span_y : i_span_x);
        w_sy   = ADDR_W'(w_swap ? i_span_x : i_span_y);
        // Flips wrap: a coordinate past the frame edge goes negative.
        w_tx   = i_cfg.orientation[0]
               ? ADDR_W'(i_cfg.frame_width) - ADDR_W'(1) - w_sx : w_sx;
        w_ty   = i_cfg.orientation[1]
               ? ADDR_W'(i_cfg.frame_height) - ADDR_W'(1) - w_sy : w_sy;
        // Walking direction: along the line unless swapped, then down columns.
        w_neg  = w_swap ? i_cfg.orientation[1] : i_cfg.orientation[0];
        w_adv  = w_swap ? ADDR_W'(i_cfg.line_stride) : ADDR_W'(1);
        // Only the low address bits are kept, so the product stays 27 bits.
        w_prod = w_ty * ADDR_W'(i_cfg.line_stride);
        w_start = w_prod + w_tx;

        n_cur  = r_cur;
        n_step = r_step;
        if (i_span_load) begin
            n_cur  = w_start;
            n_step = w_neg ? (ADDR_W'(0) - w_adv) : w_adv;
        end else if (i_pixel_step) begin
            n_cur  = r_cur + r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_step <= ADDR_W'(1);
        end else begin
            r_cur  <= n_cur;
            r_step <= n_step;
        end
    end

    assign o_address = r_cur;

endmodule
`default_nettype wire

[hw/rtl/osb_pen_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// osb_pen_ram: pen table
// One write and one registered read per cycle; contents undefined until written.
// ----------------------------------------------------------------------------
module osb_pen_ram (
    input  wire logic                           i_clk,
    input  wire logic                           i_wr_en,
    input  wire logic [osb_pkg::PEN_IDX_W-1:0]  i_wr_addr,
    input  wire logic [osb_pkg::PIX_W-1:0]      i_wr_data,
    input  wire logic                           i_rd_en,
    input  wire logic [osb_pkg::PEN_IDX_W-1:0]  i_rd_addr,
    output logic [osb_pkg::PIX_W-1:0]           o_rd_data
);
    import osb_pkg::*;

    logic [PIX_W-1:0] r_mem [PEN_COUNT];
    logic [PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[hw/rtl/osb_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// osb_checker: port-level checks for the oriented scanline pen blitter
// Watches the top level's ports for output stalls, reset, backpressure and
// result timing.
// ----------------------------------------------------------------------------
module osb_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        o_in_ready,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [24:0] o_write_address,
    input  wire logic [15:0] o_write_data
);

    // A stalled out beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_write_address) && $stable(o_write_data))
        else $error("out beat changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("out valid after reset");

    // Input backpressure only ever comes from a stalled output.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input not ready without output stall");

    // A new result has passed the pen read stage and then the output register after the beat that caused it.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("out beat without an input beat two cycles earlier");

endmodule

bind oriented_scanline_pen_blitter_top osb_checker u_osb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_write_address (o_write_address),
    .o_write_data    (o_write_data)
);
`default_nettype wire
